### hw/rtl/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ubsr_pkg.sv
package ubsr_pkg;

  localparam int MAX_BYTES   = 8;
  localparam int WORD_W      = 64;
  localparam int LEN_W       = 16;
  localparam int OFF_W       = 3;
  localparam int VB_W        = 4;
  localparam int RD_W        = LEN_W + 1;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 72;

  localparam logic [7:0] FILL_HELD  = 8'hE1;
  localparam logic [7:0] FILL_FLUSH = 8'hE2;

  localparam logic [1:0] MODE_DIRECT = 2'd0;
  localparam logic [1:0] MODE_WAIT   = 2'd1;
  localparam logic [1:0] MODE_JOIN   = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] aligned_word;
    logic [VB_W-1:0]   valid_bytes;
    logic              last_of_burst;
  } out_item_t;

endpackage

### hw/rtl/unaligned_byte_stream_realigner_core.sv
// Byte-lane realigner for memory bursts whose payload begins part way into
// the first word. The input stream carries one memory word per transaction;
// tuser marks the first word of a burst, and the offset and length fields are
// sampled on that transaction only. The output stream gives the payload
// repacked to start at byte 0, with the count of payload bytes in tdata and
// tlast on the final word of the burst.
// Each accepted word is decoded and shifted in the same cycle and its result is
// written into a three-entry output queue whose head entry is presented; the
// first word of a wait-mode burst is only held. One word per cycle is sustained
// while out_tready stays high; the flush word that closes a join-mode burst with
// equal read and write counts takes an extra queue entry and stalls the input.
// Words that arrive outside a burst, or in a burst of zero length, give no
// output. A new burst start abandons any burst still in progress.
// Reset clears the queue and the burst counters; no output is presented until
// a burst start has been accepted. When the receiver stalls, results wait in
// the queue and in_tready drops once two or more are waiting.
module unaligned_byte_stream_realigner_core
  import ubsr_pkg::*;
#(
  parameter int WORD_BYTES = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // byte_offset [2:0], payload_length [18:3], mem_word [82:19], zero [87:83]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // burst_start [0]
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // aligned_word [63:0], valid_bytes [67:64], zero [71:68]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam int QDEPTH = 3;
  localparam logic [RD_W-1:0]  RD_STEP = RD_W'(WORD_BYTES);
  localparam logic [LEN_W-1:0] WR_STEP = LEN_W'(WORD_BYTES);

  logic [1:0]        mode_r, mode_nxt;
  logic [OFF_W-1:0]  sh_r, sh_nxt;
  logic [RD_W-1:0]   rd_r, rd_nxt;
  logic [LEN_W-1:0]  wr_r, wr_nxt;
  logic [WORD_W-1:0] held_r, held_nxt;
  out_item_t         q_r [QDEPTH];
  out_item_t         q_nxt [QDEPTH];
  logic [1:0]        cnt_r, cnt_nxt;

  logic              accept, pop, active, last_rd;
  logic [OFF_W-1:0]  in_off, sh_mod, e_sh;
  logic [LEN_W-1:0]  in_len, e_wr, wr_mid;
  logic [WORD_W-1:0] in_word;
  logic [RD_W-1:0]   e_rd, start_rd;
  logic [1:0]        e_mode;
  logic [1:0]        push_n;
  logic [1:0]        base;
  out_item_t         push_a, push_b;

  // Joins lo (lanes 0..W-1) with hi (lanes W..2W-1) and shifts right by sh.
  function automatic logic [WORD_W-1:0] realign(input logic [WORD_W-1:0] lo,
                                                input logic [WORD_W-1:0] hi,
                                                input logic [OFF_W-1:0] sh);
    logic [7:0]        lob [MAX_BYTES];
    logic [7:0]        hib [MAX_BYTES];
    logic [WORD_W-1:0] w;
    logic [OFF_W:0]    j;
    logic [OFF_W:0]    jh;
    for (int i = 0; i < MAX_BYTES; i++) begin
      lob[i] = lo[i*8 +: 8];
      hib[i] = hi[i*8 +: 8];
    end
    w = '0;
    for (int k = 0; k < WORD_BYTES; k++) begin
      j  = (OFF_W+1)'(k) + {1'b0, sh};
      jh = j - (OFF_W+1)'(WORD_BYTES);
      if (j < (OFF_W+1)'(WORD_BYTES)) begin
        w[k*8 +: 8] = lob[j[OFF_W-1:0]];
      end else begin
        w[k*8 +: 8] = hib[jh[OFF_W-1:0]];
      end
    end
    return w;
  endfunction

  function automatic out_item_t make_item(input logic [WORD_W-1:0] word,
                                          input logic [LEN_W-1:0] wr);
    out_item_t it;
    it.aligned_word  = word;
    it.last_of_burst = (wr != '0) && (wr <= WR_STEP);
    it.valid_bytes   = it.last_of_burst ? wr[VB_W-1:0] : VB_W'(WORD_BYTES);
    return it;
  endfunction

  function automatic logic [LEN_W-1:0] wr_after(input logic [LEN_W-1:0] wr);
    return (wr <= WR_STEP) ? '0 : wr - WR_STEP;
  endfunction

  assign in_off  = in_tdata[2:0];
  assign in_len  = in_tdata[18:3];
  assign in_word = in_tdata[82:19];

  assign accept     = in_tvalid && in_tready;
  assign pop        = out_tvalid && out_tready;
  assign in_tready  = (cnt_r <= 2'd1);
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {{(OUT_TDATA_W-WORD_W-VB_W){1'b0}}, q_r[0].valid_bytes,
                       q_r[0].aligned_word};
  assign out_tlast  = q_r[0].last_of_burst;

  // Offset modulo the word size; the offset is narrow, so a few subtracts do.
  always_comb begin
    sh_mod = in_off;
    for (int i = 0; i < MAX_BYTES / 2; i++) begin
      if ({1'b0, sh_mod} >= (OFF_W+1)'(WORD_BYTES)) begin
        sh_mod = OFF_W'({1'b0, sh_mod} - (OFF_W+1)'(WORD_BYTES));
      end
    end
  end

  assign start_rd = (in_len == '0) ? '0 : RD_W'(sh_mod) + RD_W'(in_len);

  always_comb begin
    if (in_tuser) begin
      e_sh   = sh_mod;
      e_rd   = start_rd;
      e_wr   = in_len;
      e_mode = (sh_mod == '0 || start_rd <= RD_STEP) ? MODE_DIRECT : MODE_WAIT;
    end else begin
      e_sh   = sh_r;
      e_rd   = rd_r;
      e_wr   = wr_r;
      e_mode = mode_r;
    end
  end

  assign active  = (e_rd != '0);
  assign last_rd = (e_rd <= RD_STEP);
  assign wr_mid  = wr_after(e_wr);

  always_comb begin
    mode_nxt = mode_r;
    sh_nxt   = sh_r;
    rd_nxt   = rd_r;
    wr_nxt   = wr_r;
    held_nxt = held_r;
    push_n   = 2'd0;
    push_a   = make_item(realign(in_word, {MAX_BYTES{FILL_HELD}}, e_sh), e_wr);
    push_b   = make_item(realign(in_word, {MAX_BYTES{FILL_FLUSH}}, e_sh), wr_mid);
    if (accept) begin
      mode_nxt = e_mode;
      sh_nxt   = e_sh;
      rd_nxt   = e_rd;
      wr_nxt   = e_wr;
      if (active) begin
        rd_nxt = last_rd ? '0 : e_rd - RD_STEP;
        case (e_mode)
          MODE_DIRECT: begin
            push_n = 2'd1;
            wr_nxt = wr_mid;
          end
          MODE_WAIT: begin
            held_nxt = in_word;
            mode_nxt = MODE_JOIN;
          end
          MODE_JOIN: begin
            held_nxt = in_word;
            push_a   = make_item(realign(held_r, in_word, e_sh), e_wr);
            push_n   = 2'd1;
            wr_nxt   = wr_mid;
            // The last read still owes a word: flush it against filler.
            if (last_rd && wr_mid != '0) begin
              push_n = 2'd2;
              wr_nxt = wr_after(wr_mid);
            end
          end
          default: begin
            mode_nxt = MODE_DIRECT;
          end
        endcase
      end
    end
  end

  // Output queue: entry 0 is presented; new results append behind the rest.
  always_comb begin
    base = cnt_r - {1'b0, pop};
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        q_nxt[i] = q_r[i+1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (push_n != 2'd0 && 2'(i) == base) begin
        q_nxt[i] = push_a;
      end
      if (push_n == 2'd2 && 2'(i) == base + 2'd1) begin
        q_nxt[i] = push_b;
      end
    end
    cnt_nxt = base + push_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_DIRECT;
      sh_r   <= '0;
      rd_r   <= '0;
      wr_r   <= '0;
      cnt_r  <= 2'd0;
    end else begin
      mode_r <= mode_nxt;
      sh_r   <= sh_nxt;
      rd_r   <= rd_nxt;
      wr_r   <= wr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

### hw/rtl/ubsr_checker.sv
`include "assert_macros.svh"

module ubsr_checker
  import ubsr_pkg::*;
#(
  parameter int WORD_BYTES = 8
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  logic [VB_W-1:0] vb;
  logic            in_fire;

  assign vb      = out_tdata[WORD_W +: VB_W];
  assign in_fire = in_tvalid && in_tready;

  `ASSERT_IMPLIES(a_vb_range, clk, rst_n, out_tvalid, (vb != '0) && (vb <= VB_W'(WORD_BYTES)), "valid byte count out of range")

  `ASSERT_IMPLIES(a_full_unless_last, clk, rst_n, out_tvalid && !out_tlast, vb == VB_W'(WORD_BYTES), "partial word before the end of a burst")

  `ASSERT_IMPLIES(a_out_from_in, clk, rst_n, out_tvalid && !$past(out_tvalid), $past(in_fire), "result appeared without an input transaction")

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output transaction changed")

endmodule

bind unaligned_byte_stream_realigner_core ubsr_checker #(
  .WORD_BYTES(WORD_BYTES)
) u_ubsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);
